/* rtl/bpgc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpgc_pkg;

	localparam int WORD_BITS      = 64;
	localparam int START_BITS     = 40;
	localparam int WPB_BITS       = 22;
	localparam int SALT_BITS      = 8;
	localparam int SALT_SHIFT     = 56;
	localparam int MUL_DIGIT_BITS = 10;
	localparam int MUL_STEPS      = START_BITS / MUL_DIGIT_BITS;
	localparam int MUL_CNT_BITS   = $clog2(MUL_STEPS);

	localparam logic [WORD_BITS-1:0] BLOCK_FACTOR = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_BITS-1:0] WORD_STEP    = 64'h94d049bb133111eb;
	localparam logic [WORD_BITS-1:0] SIG_BASE     = 64'h9e3779b97f4a7c15;
	localparam logic [SALT_BITS-1:0] SALT_RESET   = 8'h51;
	localparam logic [WPB_BITS-1:0]  WPB_RESET    = 22'd512;

	typedef enum logic [1:0] {
		CMD_RESTART  = 2'd0,
		CMD_GENERATE = 2'd1,
		CMD_CHECK    = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_WORDS_PER_BLOCK = 1'b0,
		CFG_PATTERN_SALT    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]  expected_word;
		logic                  word_mismatch;
		logic                  span_failed;
		logic                  any_failure;
		logic [START_BITS-1:0] first_bad_block;
		logic [START_BITS-1:0] current_block;
	} res_t;

	function automatic logic [WORD_BITS-1:0] first_word(
		input logic [SALT_BITS-1:0] salt,
		input logic [WORD_BITS-1:0] product
	);
		logic [WORD_BITS-1:0] salt_word;
		salt_word = {salt, {SALT_SHIFT{1'b0}}};
		return SIG_BASE ^ salt_word ^ product;
	endfunction

endpackage

`default_nettype wire

/* rtl/bpgc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpgc_mul (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire logic [bpgc_pkg::START_BITS-1:0]     operand,
	output bpgc_pkg::mul_stat_t                      stat,
	output logic [bpgc_pkg::WORD_BITS-1:0]           product
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [bpgc_pkg::MUL_CNT_BITS-1:0]     cnt_q;
	logic [bpgc_pkg::WORD_BITS-1:0]        acc_q;
	logic [bpgc_pkg::WORD_BITS-1:0]        fac_q;
	logic [bpgc_pkg::START_BITS-1:0]       opnd_q;
	logic [bpgc_pkg::WORD_BITS-1:0]        pp;

	// one digit of the block index times the shifted factor, mod 2^64
	assign pp = fac_q * bpgc_pkg::WORD_BITS'(opnd_q[bpgc_pkg::MUL_DIGIT_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bpgc_pkg::MUL_CNT_BITS'(bpgc_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q  <= '0;
			fac_q  <= bpgc_pkg::BLOCK_FACTOR;
			opnd_q <= operand;
		end else if (busy_q) begin
			acc_q  <= acc_q + pp;
			fac_q  <= fac_q << bpgc_pkg::MUL_DIGIT_BITS;
			opnd_q <= opnd_q >> bpgc_pkg::MUL_DIGIT_BITS;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

`default_nettype wire

/* rtl/block_pattern_gen_check_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Block signature generator and checker. Generate and check items are taken one per
// cycle while in_stall is low and each gives one result; the signature, block counter
// and span record advance in a single registered step. A restart item stalls the input
// while its block index goes through a four-step digit multiplier for the block
// product, and the restart result leaves once that product is ready. Results pass
// through an output register with a one-entry skid, so input transfers continue while
// one result waits downstream. Configuration writes are always ready; a new salt applies
// from the next block start or restart.
module block_pattern_gen_check_top #(
	parameter int BLOCK_INDEX_BITS = 40,
	parameter int MAX_BLOCK_WORDS  = 2097152
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          command,
	input  wire logic [bpgc_pkg::START_BITS-1:0]     start_block,
	input  wire logic [bpgc_pkg::WORD_BITS-1:0]      read_word,
	input  wire logic                                last_of_span,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [bpgc_pkg::WORD_BITS-1:0]           expected_word,
	output logic                                     word_mismatch,
	output logic                                     span_failed,
	output logic                                     any_failure,
	output logic [bpgc_pkg::START_BITS-1:0]          first_bad_block,
	output logic [bpgc_pkg::START_BITS-1:0]          current_block,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [bpgc_pkg::WPB_BITS-1:0]       cfg_data
);

	localparam int BIB      = BLOCK_INDEX_BITS;
	localparam int WIB_BITS = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
	localparam logic [63:0] BLOCK_MASK = (64'd1 << BLOCK_INDEX_BITS) - 64'd1;

	logic [bpgc_pkg::WPB_BITS-1:0]  wpb_q;
	logic [bpgc_pkg::SALT_BITS-1:0] salt_q;

	logic [bpgc_pkg::WORD_BITS-1:0] pattern_word_q;
	logic [bpgc_pkg::WORD_BITS-1:0] block_product_q;
	logic [WIB_BITS-1:0]            word_in_block_q;
	logic [BIB-1:0]                 block_counter_q;
	logic [BIB-1:0]                 span_start_q;
	logic                           span_error_q;
	logic                           failed_q;
	logic [BIB-1:0]                 first_bad_q;
	logic [BIB-1:0]                 rs_block_q;

	bpgc_pkg::res_t out_q, sk_q, push_data, item_res, restart_res;
	logic           out_valid_q, sk_valid_q;

	bpgc_pkg::mul_stat_t            mul_stat;
	logic [bpgc_pkg::WORD_BITS-1:0] mul_product;

	logic        acc_ok, is_restart, mul_go, item_go, push, out_free;
	logic [63:0] start_ext;
	logic [63:0] bc_ext, fb_ext, rs_ext;

	logic [bpgc_pkg::WPB_BITS-1:0]  eff_words;
	logic [bpgc_pkg::WPB_BITS:0]    wib_next;
	logic                           wrap;
	logic                           mism, err, sfail;
	logic [BIB-1:0]                 bc_inc, bc_n, span_start_n, first_bad_n;
	logic [bpgc_pkg::WORD_BITS-1:0] prod_n, pw_n;
	logic [WIB_BITS-1:0]            wib_n;
	logic                           span_error_n, failed_n;

	assign cfg_ready = 1'b1;

	assign in_stall   = sk_valid_q | mul_stat.busy | mul_stat.done;
	assign acc_ok     = in_valid & ~in_stall;
	assign is_restart = (command == bpgc_pkg::CMD_RESTART);
	assign mul_go     = acc_ok & is_restart;
	assign item_go    = acc_ok & ~is_restart;
	assign push       = mul_stat.done | item_go;

	assign start_ext = bpgc_pkg::WORD_BITS'(start_block) & BLOCK_MASK;

	bpgc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mul_go),
		.operand (start_ext[bpgc_pkg::START_BITS-1:0]),
		.stat    (mul_stat),
		.product (mul_product)
	);

	always_comb begin
		if (wpb_q == '0) begin
			eff_words = bpgc_pkg::WPB_BITS'(1);
		end else if (wpb_q > bpgc_pkg::WPB_BITS'(MAX_BLOCK_WORDS)) begin
			eff_words = bpgc_pkg::WPB_BITS'(MAX_BLOCK_WORDS);
		end else begin
			eff_words = wpb_q;
		end

		wib_next = (bpgc_pkg::WPB_BITS + 1)'(word_in_block_q) + 1'b1;
		wrap     = wib_next >= {1'b0, eff_words};
		bc_inc   = block_counter_q + BIB'(1);

		mism = (command == bpgc_pkg::CMD_CHECK) && (read_word != pattern_word_q);
		err  = span_error_q | mism;

		if (wrap) begin
			bc_n   = bc_inc;
			prod_n = (bc_inc == '0) ? '0 : block_product_q + bpgc_pkg::BLOCK_FACTOR;
			wib_n  = '0;
			pw_n   = bpgc_pkg::first_word(salt_q, prod_n);
		end else begin
			bc_n   = block_counter_q;
			prod_n = block_product_q;
			wib_n  = wib_next[WIB_BITS-1:0];
			pw_n   = pattern_word_q + bpgc_pkg::WORD_STEP;
		end

		sfail        = 1'b0;
		failed_n     = failed_q;
		first_bad_n  = first_bad_q;
		span_error_n = err;
		span_start_n = span_start_q;
		if (last_of_span) begin
			sfail = err;
			if (err && !failed_q) begin
				failed_n    = 1'b1;
				first_bad_n = span_start_q;
			end
			span_error_n = 1'b0;
			span_start_n = bc_n;
		end

		bc_ext = 64'(block_counter_q);
		fb_ext = 64'(first_bad_n);
		rs_ext = 64'(rs_block_q);

		item_res.expected_word   = pattern_word_q;
		item_res.word_mismatch   = mism;
		item_res.span_failed     = sfail;
		item_res.any_failure     = failed_n;
		item_res.first_bad_block = fb_ext[bpgc_pkg::START_BITS-1:0];
		item_res.current_block   = bc_ext[bpgc_pkg::START_BITS-1:0];

		restart_res.expected_word   = bpgc_pkg::first_word(salt_q, mul_product);
		restart_res.word_mismatch   = 1'b0;
		restart_res.span_failed     = 1'b0;
		restart_res.any_failure     = 1'b0;
		restart_res.first_bad_block = '0;
		restart_res.current_block   = rs_ext[bpgc_pkg::START_BITS-1:0];

		push_data = mul_stat.done ? restart_res : item_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpb_q           <= bpgc_pkg::WPB_RESET;
			salt_q          <= bpgc_pkg::SALT_RESET;
			pattern_word_q  <= bpgc_pkg::first_word(bpgc_pkg::SALT_RESET, '0);
			block_product_q <= '0;
			word_in_block_q <= '0;
			block_counter_q <= '0;
			span_start_q    <= '0;
			span_error_q    <= 1'b0;
			failed_q        <= 1'b0;
			first_bad_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (bpgc_pkg::cfg_reg_t'(cfg_index))
					bpgc_pkg::CFG_WORDS_PER_BLOCK: wpb_q  <= cfg_data;
					bpgc_pkg::CFG_PATTERN_SALT:    salt_q <= cfg_data[bpgc_pkg::SALT_BITS-1:0];
					default: ;
				endcase
			end
			if (mul_stat.done) begin
				pattern_word_q  <= restart_res.expected_word;
				block_product_q <= mul_product;
				word_in_block_q <= '0;
				block_counter_q <= rs_block_q;
				span_start_q    <= rs_block_q;
				span_error_q    <= 1'b0;
				failed_q        <= 1'b0;
				first_bad_q     <= '0;
			end else if (item_go) begin
				pattern_word_q  <= pw_n;
				block_product_q <= prod_n;
				word_in_block_q <= wib_n;
				block_counter_q <= bc_n;
				span_start_q    <= span_start_n;
				span_error_q    <= span_error_n;
				failed_q        <= failed_n;
				first_bad_q     <= first_bad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			rs_block_q <= start_ext[BIB-1:0];
		end
	end

	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else begin
			if (out_free) begin
				if (sk_valid_q) begin
					out_valid_q <= 1'b1;
					sk_valid_q  <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				sk_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sk_valid_q) begin
				out_q <= sk_q;
				sk_q  <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (push) begin
			sk_q <= push_data;
		end
	end

	assign out_valid       = out_valid_q;
	assign expected_word   = out_q.expected_word;
	assign word_mismatch   = out_q.word_mismatch;
	assign span_failed     = out_q.span_failed;
	assign any_failure     = out_q.any_failure;
	assign first_bad_block = out_q.first_bad_block;
	assign current_block   = out_q.current_block;

endmodule

`default_nettype wire

/* rtl/bpgc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpgc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  command,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] expected_word,
	input  wire logic        span_failed,
	input  wire logic        any_failure,
	input  wire logic [39:0] first_bad_block,
	input  wire logic [39:0] current_block
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(expected_word)
			&& $stable(current_block))
		else $error("stalled result changed");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_failed |-> any_failure)
		else $error("span failure without sticky flag");

	a_first_bad_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !any_failure |-> first_bad_block == 40'd0)
		else $error("first bad block set without failure");

	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == bpgc_pkg::CMD_RESTART |=> in_stall)
		else $error("input open during restart");

endmodule

bind block_pattern_gen_check_top bpgc_checker u_bpgc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.command         (command),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.expected_word   (expected_word),
	.span_failed     (span_failed),
	.any_failure     (any_failure),
	.first_bad_block (first_bad_block),
	.current_block   (current_block)
);

`default_nettype wire

/* tb/block_pattern_gen_check_top_tb.sv */
`timescale 1ns / 1ps

module block_pattern_gen_check_top_tb;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int MAX_WORDS = 2097152;
	localparam logic [bpgc_pkg::START_BITS-1:0] TOP_BLOCK = {bpgc_pkg::START_BITS{1'b1}};

	typedef struct packed {
		logic [1:0]                      cmd;
		logic [bpgc_pkg::START_BITS-1:0] start;
		logic [bpgc_pkg::WORD_BITS-1:0]  rd;
		logic                            last;
		logic                            from_sig;
		logic [bpgc_pkg::WORD_BITS-1:0]  flip;
	} word_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = bpgc_pkg::CMD_GENERATE;
	logic [bpgc_pkg::START_BITS-1:0] start_block = '0;
	logic [bpgc_pkg::WORD_BITS-1:0] read_word = '0;
	logic last_of_span = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [bpgc_pkg::WORD_BITS-1:0] expected_word;
	logic word_mismatch;
	logic span_failed;
	logic any_failure;
	logic [bpgc_pkg::START_BITS-1:0] first_bad_block;
	logic [bpgc_pkg::START_BITS-1:0] current_block;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = bpgc_pkg::CFG_WORDS_PER_BLOCK;
	logic [bpgc_pkg::WPB_BITS-1:0] cfg_data = '0;

	block_pattern_gen_check_top dut (.*);

	word_req_t word_requests[$];
	bpgc_pkg::res_t predicted_results[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold_left = 0;

	logic [bpgc_pkg::WPB_BITS-1:0] sig_wpb = bpgc_pkg::WPB_RESET;
	logic [bpgc_pkg::SALT_BITS-1:0] sig_salt = bpgc_pkg::SALT_RESET;
	logic [bpgc_pkg::WORD_BITS-1:0] sig_word = bpgc_pkg::SIG_BASE ^ {bpgc_pkg::SALT_RESET, 56'd0};
	logic [bpgc_pkg::WORD_BITS-1:0] sig_product = '0;
	logic [bpgc_pkg::WPB_BITS-1:0] sig_word_idx = '0;
	logic [bpgc_pkg::START_BITS-1:0] sig_block = '0;
	logic [bpgc_pkg::START_BITS-1:0] sig_span_start = '0;
	logic sig_span_err = 1'b0;
	logic sig_failed = 1'b0;
	logic [bpgc_pkg::START_BITS-1:0] sig_first_bad = '0;

	initial forever #4 clk = ~clk;

	task automatic step_signature(input logic [1:0] cmd,
			input logic [bpgc_pkg::START_BITS-1:0] start,
			input logic [bpgc_pkg::WORD_BITS-1:0] rd, input logic last,
			output bpgc_pkg::res_t r);
		logic [bpgc_pkg::WPB_BITS:0] blk_len;
		logic mism;
		r = '0;
		mism = 1'b0;
		if (sig_wpb == '0)
			blk_len = (bpgc_pkg::WPB_BITS + 1)'(1);
		else if (sig_wpb > bpgc_pkg::WPB_BITS'(MAX_WORDS))
			blk_len = (bpgc_pkg::WPB_BITS + 1)'(MAX_WORDS);
		else
			blk_len = {1'b0, sig_wpb};
		if (cmd == bpgc_pkg::CMD_RESTART) begin
			sig_block = start;
			sig_product = {{(bpgc_pkg::WORD_BITS-bpgc_pkg::START_BITS){1'b0}}, start}
				* bpgc_pkg::BLOCK_FACTOR;
			sig_word_idx = '0;
			sig_word = bpgc_pkg::SIG_BASE ^ {sig_salt, 56'd0} ^ sig_product;
			sig_span_start = start;
			sig_span_err = 1'b0;
			sig_failed = 1'b0;
			sig_first_bad = '0;
			r.expected_word = sig_word;
			r.current_block = sig_block;
		end else begin
			r.expected_word = sig_word;
			r.current_block = sig_block;
			if (cmd == bpgc_pkg::CMD_CHECK && rd != sig_word)
				mism = 1'b1;
			sig_span_err = sig_span_err | mism;
			if ({1'b0, sig_word_idx} + 1'b1 >= blk_len) begin
				sig_block = sig_block + 1'b1;
				if (sig_block == '0)
					sig_product = '0;
				else
					sig_product = sig_product + bpgc_pkg::BLOCK_FACTOR;
				sig_word_idx = '0;
				sig_word = bpgc_pkg::SIG_BASE ^ {sig_salt, 56'd0} ^ sig_product;
			end else begin
				sig_word_idx = sig_word_idx + 1'b1;
				sig_word = sig_word + bpgc_pkg::WORD_STEP;
			end
			if (last) begin
				r.span_failed = sig_span_err;
				if (sig_span_err && !sig_failed) begin
					sig_failed = 1'b1;
					sig_first_bad = sig_span_start;
				end
				sig_span_err = 1'b0;
				sig_span_start = sig_block;
			end
			r.word_mismatch = mism;
			r.any_failure = sig_failed;
			r.first_bad_block = sig_first_bad;
		end
	endtask

	function automatic word_req_t mk_req(input logic [1:0] cmd,
			input logic [bpgc_pkg::START_BITS-1:0] start,
			input logic [bpgc_pkg::WORD_BITS-1:0] rd, input logic last, input logic from_sig,
			input logic [bpgc_pkg::WORD_BITS-1:0] flip);
		word_req_t q;
		q.cmd = cmd;
		q.start = start;
		q.rd = rd;
		q.last = last;
		q.from_sig = from_sig;
		q.flip = flip;
		return q;
	endfunction

	function automatic void check_field(input string name,
			input logic [bpgc_pkg::WORD_BITS-1:0] want,
			input logic [bpgc_pkg::WORD_BITS-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// driver: predict on transfer, then present the next request
	always @(posedge clk) begin : drive_words
		word_req_t req;
		bpgc_pkg::res_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_signature(command, start_block, read_word, last_of_span, r);
				predicted_results.push_back(r);
			end
			if (!in_valid || !in_stall) begin
				if (word_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req = word_requests.pop_front();
					command <= req.cmd;
					start_block <= req.start;
					read_word <= req.from_sig ? (sig_word ^ req.flip) : req.rd;
					last_of_span <= req.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_results
		bpgc_pkg::res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					$display("%0t unexpected result: expected none actual %h", $time, expected_word);
				end else begin
					want = predicted_results.pop_front();
					check_field("expected_word", want.expected_word, expected_word);
					check_field("word_mismatch", bpgc_pkg::WORD_BITS'(want.word_mismatch),
						bpgc_pkg::WORD_BITS'(word_mismatch));
					check_field("span_failed", bpgc_pkg::WORD_BITS'(want.span_failed),
						bpgc_pkg::WORD_BITS'(span_failed));
					check_field("any_failure", bpgc_pkg::WORD_BITS'(want.any_failure),
						bpgc_pkg::WORD_BITS'(any_failure));
					check_field("first_bad_block", bpgc_pkg::WORD_BITS'(want.first_bad_block),
						bpgc_pkg::WORD_BITS'(first_bad_block));
					check_field("current_block", bpgc_pkg::WORD_BITS'(want.current_block),
						bpgc_pkg::WORD_BITS'(current_block));
				end
			end
		end
	end

	always @(posedge clk) begin : drive_stall
		if (arst_n) begin
			if (recv_hold_left > 0) begin
				out_stall <= 1'b1;
				recv_hold_left <= recv_hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic write_reg(input bpgc_pkg::cfg_reg_t idx,
			input logic [bpgc_pkg::WPB_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == bpgc_pkg::CFG_WORDS_PER_BLOCK)
			sig_wpb = val;
		else
			sig_salt = val[bpgc_pkg::SALT_BITS-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (word_requests.size() != 0 || in_valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic queue_random(input int n);
		int pick;
		logic [1:0] cmd;
		logic [bpgc_pkg::START_BITS-1:0] start;
		logic [bpgc_pkg::WORD_BITS-1:0] flip;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			cmd = (pick < 6) ? bpgc_pkg::CMD_RESTART : (pick < 9) ? CMD_SPARE :
				(pick < 50) ? bpgc_pkg::CMD_GENERATE : bpgc_pkg::CMD_CHECK;
			start = bpgc_pkg::START_BITS'({$urandom, $urandom});
			if ($urandom_range(3) == 0)
				start = TOP_BLOCK - bpgc_pkg::START_BITS'($urandom_range(3));
			pick = $urandom_range(99);
			flip = '0;
			if (pick < 6)
				flip = 64'd1 << $urandom_range(63);
			else if (pick < 10)
				flip = {$urandom, $urandom};
			word_requests.push_back(mk_req(cmd, start, {$urandom, $urandom},
				$urandom_range(5) == 0, $urandom_range(9) != 0, flip));
		end
	endtask

	task automatic run_phase(input logic [bpgc_pkg::WPB_BITS-1:0] wpb,
			input logic [bpgc_pkg::WPB_BITS-1:0] salt,
			input int n, input int send_pct, input int recv_pct, input int hold);
		write_reg(bpgc_pkg::CFG_WORDS_PER_BLOCK, wpb);
		write_reg(bpgc_pkg::CFG_PATTERN_SALT, salt);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		recv_hold_left = hold;
		queue_random(n);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		word_requests.push_back(mk_req(bpgc_pkg::CMD_GENERATE, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1, 64'd1));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1,
			64'h8000_0000_0000_0000));
		word_requests.push_back(mk_req(CMD_SPARE, '0, '1, 1'b1, 1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b0, 1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '1, 1'b1, 1'b0, '0));
		drain();

		write_reg(bpgc_pkg::CFG_WORDS_PER_BLOCK, 22'd2);
		write_reg(bpgc_pkg::CFG_PATTERN_SALT, 22'hFF);
		@(negedge clk);
		// wrap past the top block index
		word_requests.push_back(mk_req(bpgc_pkg::CMD_RESTART, TOP_BLOCK, '0, 1'b1, 1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_GENERATE, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_GENERATE, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_GENERATE, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1, '1));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_RESTART, '0, '0, 1'b0, 1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_GENERATE, '0, '0, 1'b1, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_RESTART, 40'h55_5555_5555, '0, 1'b0,
			1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b0, 1'b1, '0));
		word_requests.push_back(mk_req(CMD_SPARE, '0, '0, 1'b1, 1'b1, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_RESTART, 40'hAA_AAAA_AAAA, '0, 1'b1,
			1'b0, '0));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b0, 1'b1, 64'd1));
		word_requests.push_back(mk_req(bpgc_pkg::CMD_CHECK, '0, '0, 1'b1, 1'b1, '0));
		drain();

		run_phase(22'd1, 22'h0, 150, 0, 0, 0);
		run_phase(22'd0, 22'h3FFF5A, 110, 63, 0, 0);
		run_phase(22'd3, 22'hA5, 110, 0, 63, 0);
		run_phase(22'h3FFFFF, 22'h80, 90, 7, 7, 0);
		// hold the receiver off so the block backs up into its input
		run_phase(22'd2097152, 22'h01, 60, 0, 0, 200);
		run_phase(22'd5, bpgc_pkg::WPB_BITS'($urandom_range(255)), 90, 30, 30, 0);
		run_phase(22'd2, 22'h33, 40, 0, 0, 0);

		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* block_pattern_gen_check_top.f */
rtl/bpgc_pkg.sv
rtl/bpgc_mul.sv
rtl/block_pattern_gen_check_top.sv
rtl/bpgc_checker.sv
tb/block_pattern_gen_check_top_tb.sv
